>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the address escape encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/addr_esc_pkg.sv
// ----------------------------------------------------------------------------
// addr_esc_pkg
// Types, character codes and lookup functions of the address escape encoder.
// ----------------------------------------------------------------------------
package addr_esc_pkg;

   typedef enum logic [1:0] {
      MODE_RFC822  = 2'd0,
      MODE_XTEXT   = 2'd1,
      MODE_UTF8    = 2'd2,
      MODE_UNITEXT = 2'd3
   } mode_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        first;
      logic        no_char;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       empty;
   } gen_out_type;

   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   localparam logic [2:0] PREFIX_822_LEN = 3'd7;
   localparam logic [2:0] PREFIX_UTF_LEN = 3'd6;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
   endfunction

   // Byte idx of the type prefix; "rfc822;" for rfc822 mode, "utf-8;" otherwise.
   function automatic logic [7:0] prefix_char(input mode_type mode, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (mode == MODE_RFC822) begin
         case (idx)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h66;
            3'd2:    c = 8'h63;
            3'd3:    c = 8'h38;
            3'd4:    c = 8'h32;
            3'd5:    c = 8'h32;
            default: c = 8'h3B;
         endcase
      end else begin
         case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h66;
            3'd3:    c = 8'h2D;
            3'd4:    c = 8'h38;
            default: c = 8'h3B;
         endcase
      end
      prefix_char = c;
   endfunction

   function automatic logic byte_needs_escape(input logic [7:0] b);
      byte_needs_escape = (b < 8'h21) || (b > 8'h7E) || (b == CHAR_PLUS) ||
                          (b == CHAR_EQUAL) || (b == CHAR_BSLASH);
   endfunction

endpackage

>>> design/addr_esc_gen.sv
// ----------------------------------------------------------------------------
// addr_esc_gen
// Computes the encoded byte at a given position of one item's output text,
// together with the last-byte and empty-item flags.
// ----------------------------------------------------------------------------
module addr_esc_gen (
   input  addr_esc_pkg::req_word_type item,
   input  addr_esc_pkg::mode_type     mode,
   input  logic [4:0]                 pos,
   output addr_esc_pkg::gen_out_type  gen
);
   import addr_esc_pkg::*;

   logic [20:0]      cp;
   logic [3:0][7:0]  utf;
   logic [2:0]       utf_len;
   logic [2:0]       plen;
   logic [4:0]       rel;
   logic [3:0]       besc;
   logic [3:0][2:0]  seg;
   logic [4:0]       off1, off2, off3, blen;
   logic [1:0]       k;
   logic [4:0]       koff;
   logic [2:0]       sub;
   logic [7:0]       bk;
   logic [7:0]       byte_mode_out;
   logic             cesc;
   logic [2:0]       ndig;
   logic [4:0]       clen;
   logic [2:0]       dig_idx;
   logic [5:0][3:0]  nibs;
   logic [7:0]       uni_out;
   logic [4:0]       char_len;
   logic [4:0]       total;

   assign cp   = item.code_point;
   assign nibs = {3'b000, cp};

   // UTF-8 bit pattern, sized by the code point only.
   always_comb begin
      utf = '0;
      if (cp < 21'h80) begin
         utf[0]  = cp[7:0];
         utf_len = 3'd1;
      end else if (cp < 21'h800) begin
         utf[0]  = {3'b110, cp[10:6]};
         utf[1]  = {2'b10, cp[5:0]};
         utf_len = 3'd2;
      end else if (cp < 21'h10000) begin
         utf[0]  = {4'b1110, cp[15:12]};
         utf[1]  = {2'b10, cp[11:6]};
         utf[2]  = {2'b10, cp[5:0]};
         utf_len = 3'd3;
      end else begin
         utf[0]  = {5'b11110, cp[20:18]};
         utf[1]  = {2'b10, cp[17:12]};
         utf[2]  = {2'b10, cp[11:6]};
         utf[3]  = {2'b10, cp[5:0]};
         utf_len = 3'd4;
      end
   end

   always_comb begin
      if (!item.first) begin
         plen = 3'd0;
      end else if (mode == MODE_RFC822) begin
         plen = PREFIX_822_LEN;
      end else begin
         plen = PREFIX_UTF_LEN;
      end
   end

   assign rel = pos - {2'b00, plen};

   // Byte escape modes: each UTF-8 byte expands to 1, 3 or 6 output bytes.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         besc[i] = byte_needs_escape(utf[i]);
         if (3'(i) >= utf_len) begin
            seg[i] = 3'd0;
         end else if (!besc[i]) begin
            seg[i] = 3'd1;
         end else if (mode == MODE_XTEXT) begin
            seg[i] = 3'd6;
         end else begin
            seg[i] = 3'd3;
         end
      end
   end

   assign off1 = {2'b00, seg[0]};
   assign off2 = off1 + {2'b00, seg[1]};
   assign off3 = off2 + {2'b00, seg[2]};
   assign blen = off3 + {2'b00, seg[3]};

   always_comb begin
      if (utf_len > 3'd3 && rel >= off3) begin
         k    = 2'd3;
         koff = off3;
      end else if (utf_len > 3'd2 && rel >= off2) begin
         k    = 2'd2;
         koff = off2;
      end else if (utf_len > 3'd1 && rel >= off1) begin
         k    = 2'd1;
         koff = off1;
      end else begin
         k    = 2'd0;
         koff = 5'd0;
      end
   end

   assign sub = 3'(rel - koff);
   assign bk  = utf[k];

   always_comb begin
      if (!besc[k]) begin
         byte_mode_out = bk;
      end else if (mode == MODE_RFC822) begin
         case (sub)
            3'd0:    byte_mode_out = CHAR_PLUS;
            3'd1:    byte_mode_out = hex_char(bk[7:4]);
            default: byte_mode_out = hex_char(bk[3:0]);
         endcase
      end else begin
         case (sub)
            3'd0:    byte_mode_out = CHAR_BSLASH;
            3'd1:    byte_mode_out = CHAR_X;
            3'd2:    byte_mode_out = CHAR_LBRACE;
            3'd3:    byte_mode_out = hex_char(bk[7:4]);
            3'd4:    byte_mode_out = hex_char(bk[3:0]);
            default: byte_mode_out = CHAR_RBRACE;
         endcase
      end
   end

   // Code point modes: escaped characters become \x{...} with no leading zeros.
   assign cesc = (cp <= 21'(CHAR_SPACE)) || (cp == 21'(CHAR_BSLASH)) ||
                 (cp == 21'(CHAR_PLUS)) || (cp == 21'(CHAR_EQUAL)) ||
                 (cp == 21'(CHAR_DEL)) || (mode == MODE_UNITEXT && cp > 21'(CHAR_DEL));

   always_comb begin
      if (cp[20]) begin
         ndig = 3'd6;
      end else if (cp[19:16] != 4'h0) begin
         ndig = 3'd5;
      end else if (cp[15:12] != 4'h0) begin
         ndig = 3'd4;
      end else if (cp[11:8] != 4'h0) begin
         ndig = 3'd3;
      end else if (cp[7:4] != 4'h0) begin
         ndig = 3'd2;
      end else begin
         ndig = 3'd1;
      end
   end

   assign clen    = cesc ? (5'd4 + {2'b00, ndig}) : {2'b00, utf_len};
   assign dig_idx = 3'({2'b00, ndig} + 5'd2 - rel);

   always_comb begin
      if (!cesc) begin
         uni_out = utf[rel[1:0]];
      end else if (rel == 5'd0) begin
         uni_out = CHAR_BSLASH;
      end else if (rel == 5'd1) begin
         uni_out = CHAR_X;
      end else if (rel == 5'd2) begin
         uni_out = CHAR_LBRACE;
      end else if (rel == {2'b00, ndig} + 5'd3) begin
         uni_out = CHAR_RBRACE;
      end else begin
         uni_out = hex_char(nibs[dig_idx]);
      end
   end

   always_comb begin
      if (item.no_char) begin
         char_len = 5'd0;
      end else if (mode == MODE_RFC822 || mode == MODE_XTEXT) begin
         char_len = blen;
      end else begin
         char_len = clen;
      end
   end

   assign total = {2'b00, plen} + char_len;

   always_comb begin
      gen.empty = (total == 5'd0);
      gen.last  = (pos == total - 5'd1);
      if (pos < {2'b00, plen}) begin
         gen.out_byte = prefix_char(mode, pos[2:0]);
      end else if (mode == MODE_RFC822 || mode == MODE_XTEXT) begin
         gen.out_byte = byte_mode_out;
      end else begin
         gen.out_byte = uni_out;
      end
   end

endmodule

>>> design/address_escape_encoder.sv
// ----------------------------------------------------------------------------
// address_escape_encoder
// Escapes one Unicode code point of a mail address per request word and
// streams the encoded text out one byte per response word.
// ----------------------------------------------------------------------------
// Each request word yields one response word per byte it produces, one per
// cycle unless the receiver stalls: one to six for typical characters, up to
// 30 with prefix and four escaped bytes in xtext mode; the single output byte
// register sets this pace. A word with no_char set and first clear produces no
// bytes and retires without an output slot. The next request word is taken in
// the cycle its predecessor emits its last byte, so the stream runs without
// gaps. The user must write encode_mode through the csr port only while the
// block is idle (not enforced); rfc822 = 0, xtext = 1, utf8 = 2, unitext = 3.
`include "assert_macros.svh"

module address_escape_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  addr_esc_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output addr_esc_pkg::rsp_word_type rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_data
);
   import addr_esc_pkg::*;

   mode_type     mode_ff, mode_in;
   req_word_type work_ff, work_in;
   logic         work_valid_ff, work_valid_in;
   logic [4:0]   pos_ff, pos_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   gen_out_type  gen;
   logic         emit_ok;
   logic         advance;
   logic         done;
   logic         accept;

   addr_esc_gen u_gen (
      .item (work_ff),
      .mode (mode_ff),
      .pos  (pos_ff),
      .gen  (gen)
   );

   assign csr_ready = 1'b1;
   assign mode_in   = csr_valid ? mode_type'(csr_data) : mode_ff;

   assign emit_ok   = !rsp_valid_ff || !rsp_stall;
   // An empty word needs no output slot and retires at once.
   assign advance   = work_valid_ff && (gen.empty || emit_ok);
   assign done      = advance && (gen.empty || gen.last);
   assign req_stall = work_valid_ff && !done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      pos_in        = pos_ff;
      if (accept) begin
         work_in       = req_data;
         work_valid_in = 1'b1;
         pos_in        = 5'd0;
      end else if (done) begin
         work_valid_in = 1'b0;
      end else if (advance) begin
         pos_in = pos_ff + 5'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_ok) begin
         rsp_valid_in         = advance && !gen.empty;
         rsp_data_in.out_byte = gen.out_byte;
         rsp_data_in.last     = gen.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RFC822;
         work_valid_ff <= 1'b0;
         pos_ff        <= 5'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         work_valid_ff <= work_valid_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLY(a_rsp_from_work, clock, reset, $rose(rsp_valid_ff), $past(work_valid_ff), "response word appeared without a word in progress")
   `ASSERT_NEXT(a_done_retires, clock, reset, done && !accept, !work_valid_ff, "finished word did not retire")
   `ASSERT_NEXT(a_pos_steps, clock, reset, advance && !done && !accept, pos_ff == $past(pos_ff) + 5'd1, "byte position did not step by one")

endmodule

>>> test/addr_esc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addr_esc_checker
// Watches the request, response and register channels of the address escape
// encoder, works out the escaped text of every accepted request word and
// compares each response word with the oldest byte still owed.
// ----------------------------------------------------------------------------
module addr_esc_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  addr_esc_pkg::req_word_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  addr_esc_pkg::rsp_word_type rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [1:0]                 csr_data,
   output int                         fail_count,
   output int                         pending
);
   import addr_esc_pkg::*;

   string        hex_set = "0123456789ABCDEF";
   mode_type     mode_copy;
   rsp_word_type expected_text[$];
   rsp_word_type oldest;

   function automatic void put_text_byte(input logic [7:0] b);
      rsp_word_type r;
      r.out_byte = b;
      r.last     = 1'b0;
      expected_text = {expected_text, r};
   endfunction

   function automatic void put_hex_pair(input logic [7:0] b);
      put_text_byte(hex_set[b[7:4]]);
      put_text_byte(hex_set[b[3:0]]);
   endfunction

   // Appends the bytes that one request word must produce, marking the final one.
   function automatic void escape_char(input mode_type mode, input req_word_type w);
      string        prefix;
      logic [7:0]   utf [4];
      int           len;
      int           base;
      logic [20:0]  cp;
      logic [23:0]  wide;
      logic         started;
      logic         esc;
      logic         plain;
      base = expected_text.size();
      cp   = w.code_point;
      wide = {3'b000, cp};
      if (w.first) begin
         prefix = (mode == MODE_RFC822) ? "rfc822;" : "utf-8;";
         for (int i = 0; i < prefix.len(); i++) put_text_byte(prefix[i]);
      end
      if (!w.no_char) begin
         if (cp < 21'h80) begin
            utf[0] = cp[7:0];
            len = 1;
         end else if (cp < 21'h800) begin
            utf[0] = {3'b110, cp[10:6]};
            utf[1] = {2'b10, cp[5:0]};
            len = 2;
         end else if (cp < 21'h10000) begin
            utf[0] = {4'b1110, cp[15:12]};
            utf[1] = {2'b10, cp[11:6]};
            utf[2] = {2'b10, cp[5:0]};
            len = 3;
         end else begin
            utf[0] = {5'b11110, cp[20:18]};
            utf[1] = {2'b10, cp[17:12]};
            utf[2] = {2'b10, cp[11:6]};
            utf[3] = {2'b10, cp[5:0]};
            len = 4;
         end
         if (mode == MODE_RFC822 || mode == MODE_XTEXT) begin
            for (int i = 0; i < len; i++) begin
               plain = utf[i] >= 8'h21 && utf[i] <= 8'h7E && utf[i] != CHAR_PLUS &&
                       utf[i] != CHAR_EQUAL && utf[i] != CHAR_BSLASH;
               if (plain) begin
                  put_text_byte(utf[i]);
               end else if (mode == MODE_RFC822) begin
                  put_text_byte(CHAR_PLUS);
                  put_hex_pair(utf[i]);
               end else begin
                  put_text_byte(CHAR_BSLASH);
                  put_text_byte(CHAR_X);
                  put_text_byte(CHAR_LBRACE);
                  put_hex_pair(utf[i]);
                  put_text_byte(CHAR_RBRACE);
               end
            end
         end else begin
            esc = cp <= 21'h20 || cp == CHAR_BSLASH || cp == CHAR_PLUS ||
                  cp == CHAR_EQUAL || cp == CHAR_DEL || (mode == MODE_UNITEXT && cp > 21'h7F);
            if (esc) begin
               put_text_byte(CHAR_BSLASH);
               put_text_byte(CHAR_X);
               put_text_byte(CHAR_LBRACE);
               // Hex digits without leading zeros, but at least one digit.
               started = 1'b0;
               for (int d = 5; d >= 0; d--) begin
                  if (wide[4*d +: 4] != 4'h0 || d == 0) started = 1'b1;
                  if (started) put_text_byte(hex_set[wide[4*d +: 4]]);
               end
               put_text_byte(CHAR_RBRACE);
            end else begin
               for (int i = 0; i < len; i++) put_text_byte(utf[i]);
            end
         end
      end
      if (expected_text.size() > base) begin
         expected_text[expected_text.size() - 1].last = 1'b1;
      end
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      mode_copy  = MODE_RFC822;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_text.delete();
         mode_copy = MODE_RFC822;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, got byte %h last %b",
                        $time, rsp_data.out_byte, rsp_data.last);
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_data.out_byte !== oldest.out_byte) begin
                  fail_count++;
                  $display("%0t: out_byte expected %h, got %h",
                           $time, oldest.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.last !== oldest.last) begin
                  fail_count++;
                  $display("%0t: last expected %b, got %b", $time, oldest.last, rsp_data.last);
               end
            end
         end
         if (csr_valid && csr_ready) mode_copy = mode_type'(csr_data);
         if (req_valid && !req_stall) escape_char(mode_copy, req_data);
      end
      pending = expected_text.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the address escape encoder with directed and random characters in
// all four encode modes, under several patterns of sender gaps and receiver
// stalls, and reports whether every escaped byte matched.
// ----------------------------------------------------------------------------
module tb;
   import addr_esc_pkg::*;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_data;
   int           fail_count;
   int           pending;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_orders = 0;
   int           hold_served;
   int           hold_left;

   address_escape_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   addr_esc_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // Receiver: random stalls, or a long hold-off whenever one is ordered.
   initial begin
      rsp_stall   = 1'b0;
      hold_served = 0;
      hold_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            hold_left   = 300;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_word(input req_word_type w);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_char(input logic [20:0] cp, input logic first, input logic no_char);
      req_word_type w;
      w.code_point = cp;
      w.first      = first;
      w.no_char    = no_char;
      send_word(w);
   endtask

   // Stops offering words and waits until every owed byte is out; a word
   // without output may still be in flight, so the task keeps waiting after that.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      drain();
      csr_valid = 1'b1;
      csr_data  = m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_word_type random_char();
      req_word_type w;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: w.code_point = $urandom_range(0, 21'h7F);
         4: begin
            case ($urandom_range(0, 7))
               0:       w.code_point = 21'h0;
               1:       w.code_point = CHAR_SPACE;
               2:       w.code_point = 21'h21;
               3:       w.code_point = CHAR_PLUS;
               4:       w.code_point = CHAR_EQUAL;
               5:       w.code_point = CHAR_BSLASH;
               6:       w.code_point = 21'h7E;
               default: w.code_point = CHAR_DEL;
            endcase
         end
         5:       w.code_point = $urandom_range(21'h80, 21'h7FF);
         6:       w.code_point = $urandom_range(21'h800, 21'hFFFF);
         7:       w.code_point = $urandom_range(21'h10000, 21'h10FFFF);
         8:       w.code_point = $urandom_range(21'h110000, 21'h1FFFFF);
         default: w.code_point = $urandom_range(0, 21'h1FFFFF);
      endcase
      w.first   = ($urandom_range(0, 9) == 0);
      w.no_char = ($urandom_range(0, 11) == 0);
      return w;
   endfunction

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words in the reset mode: field extremes, every escape
      // trigger, each UTF-8 length, out-of-range values and prefix cases.
      send_char(21'h0, 1'b1, 1'b0);
      send_char(CHAR_SPACE, 1'b0, 1'b0);
      send_char(21'h21, 1'b0, 1'b0);
      send_char(CHAR_PLUS, 1'b0, 1'b0);
      send_char(CHAR_EQUAL, 1'b0, 1'b0);
      send_char(CHAR_BSLASH, 1'b0, 1'b0);
      send_char(21'h7E, 1'b0, 1'b0);
      send_char(CHAR_DEL, 1'b0, 1'b0);
      send_char(21'h80, 1'b0, 1'b0);
      send_char(21'h7FF, 1'b0, 1'b0);
      send_char(21'h800, 1'b0, 1'b0);
      send_char(21'hD800, 1'b0, 1'b0);
      send_char(21'hFFFF, 1'b0, 1'b0);
      send_char(21'h10000, 1'b0, 1'b0);
      send_char(21'h10FFFF, 1'b0, 1'b0);
      send_char(21'h110000, 1'b0, 1'b0);
      send_char(21'h1FFFFF, 1'b0, 1'b0);
      send_char(21'h41, 1'b1, 1'b1);
      send_char(21'h1FFFFF, 1'b0, 1'b1);
      // The longest output: prefix plus four escaped bytes in xtext.
      write_mode(MODE_XTEXT);
      send_char(21'h1FFFFF, 1'b1, 1'b0);
      send_char(21'h10FFFF, 1'b1, 1'b0);

      for (int p = 0; p < 8; p++) begin
         write_mode(mode_type'((3 * p + 3) % 4));
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 46;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 46;
            end
            default: begin
               send_idle_pct = 25;
               stall_pct     = 25;
            end
         endcase
         for (int i = 0; i < 50; i++) begin
            // The receiver holds off while words keep coming, so the block
            // backs up into its input.
            if (p == 4 && i == 10) hold_orders++;
            if (p == 6 && i == 25) drain();
            send_word(random_char());
         end
      end

      drain();
      repeat (30) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
